>>> src/looped_sample_voice_resampler_defines.svh
// Assertion helpers; each expects clk and rst_n in scope.
`ifndef LOOPED_SAMPLE_VOICE_RESAMPLER_DEFINES_SVH
`define LOOPED_SAMPLE_VOICE_RESAMPLER_DEFINES_SVH

// Check the consequent in the same cycle.
`define LSVR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check the consequent in the next cycle.
`define LSVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/lsvr_pkg.sv
`timescale 1ns / 1ps

package lsvr_pkg;

  localparam logic [1:0] CMD_LOAD    = 2'd0;
  localparam logic [1:0] CMD_TRIGGER = 2'd1;
  localparam logic [1:0] CMD_STEP    = 2'd2;

  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_FORWARD  = 2'd1;
  localparam logic [1:0] MODE_PINGPONG = 2'd2;
  localparam logic [1:0] MODE_HOLD     = 2'd3;

  localparam logic [1:0] REG_LOOP_MODE     = 2'd0;
  localparam logic [1:0] REG_SAMPLE_LENGTH = 2'd1;
  localparam logic [1:0] REG_LOOP_START    = 2'd2;
  localparam logic [1:0] REG_LOOP_END      = 2'd3;

  localparam int MUL_A_W    = 17;
  localparam int VOL_PROD_W = 34;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [15:0]        addr;
    logic signed [15:0] sample_in;
    logic [22:0]        advance;
    logic [15:0]        vol_left;
    logic [15:0]        vol_right;
  } in_word_t;

  typedef struct packed {
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;
    logic               playing;
  } out_word_t;

  function automatic logic signed [15:0] sat_q15(input logic signed [VOL_PROD_W-1:0] prod);
    logic signed [VOL_PROD_W-1:0] shr;
    logic signed [15:0]           res;
    shr = prod >>> 15;
    if (shr > VOL_PROD_W'(32'sd32767)) begin
      res = 16'sh7fff;
    end else if (shr < VOL_PROD_W'(-32'sd32768)) begin
      res = 16'sh8000;
    end else begin
      res = 16'(shr);
    end
    return res;
  endfunction

endpackage

>>> src/looped_sample_voice_resampler.sv
// Sample voice with linear interpolation and four loop modes. A load word writes one
// sample into the sample memory and a trigger word restarts the voice. A step word
// yields one stereo result word and is busy until it registers that word: two reads
// through the single read port of the sample memory, three products through one
// shared multiplier (blend, left gain, right gain) and three position-update steps.
// A wrap of a nonempty forward loop runs a bit-serial remainder unit. A step on a
// stopped voice skips to the output state and yields a silent word. Registers must be
// written over the APB port only while the voice is idle; keeping to this is left to
// the user. The sample memory powers up undefined; read only what was loaded.
`timescale 1ns / 1ps
`include "looped_sample_voice_resampler_defines.svh"

module looped_sample_voice_resampler #(
  parameter int MEM_DEPTH = 65536,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lsvr_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lsvr_pkg::out_word_t  out_data,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);

  localparam int ADDR_W = $clog2(MEM_DEPTH);
  localparam int POS_W  = FRAC_BITS + 18;
  localparam int PS_W   = POS_W + 2;
  localparam int IDX_W  = POS_W - FRAC_BITS;
  localparam int LEN_W  = FRAC_BITS + 17;
  localparam int REM_W  = LEN_W + 1;
  localparam int DIV_N  = POS_W + 1;
  localparam int CNT_W  = $clog2(DIV_N + 1);
  localparam int MA_W   = lsvr_pkg::MUL_A_W;
  localparam int MB_W   = (FRAC_BITS > 16) ? FRAC_BITS + 1 : 17;
  localparam int MP_W   = MA_W + MB_W;
  localparam int VP_W   = lsvr_pkg::VOL_PROD_W;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_RD1  = 14'b00000000000010,
    S_RD2  = 14'b00000000000100,
    S_SEL  = 14'b00000000001000,
    S_MI   = 14'b00000000010000,
    S_SUM  = 14'b00000000100000,
    S_ML   = 14'b00000001000000,
    S_MR   = 14'b00000010000000,
    S_PADV = 14'b00000100000000,
    S_PFIX = 14'b00001000000000,
    S_DIV  = 14'b00010000000000,
    S_WRAP = 14'b00100000000000,
    S_PCHK = 14'b01000000000000,
    S_DONE = 14'b10000000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]  loop_mode_r;
  logic [16:0] sample_length_r;
  logic [15:0] loop_start_r;
  logic [16:0] loop_end_r;

  logic [POS_W-1:0]  pos_r, pos_nxt;
  logic              fwd_r, fwd_nxt;
  logic              stopped_r, stopped_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              silent_r, silent_nxt;

  logic [22:0]              adv_r, adv_nxt;
  logic [15:0]              vl_r, vl_nxt;
  logic [15:0]              vr_r, vr_nxt;
  logic signed [15:0]       cur_r, cur_nxt;
  logic signed [15:0]       u_r, u_nxt;
  logic signed [15:0]       v_r, v_nxt;
  logic signed [MP_W-1:0]   prod_r, prod_nxt;
  logic signed [MA_W-1:0]   s_r, s_nxt;
  logic signed [15:0]       lft_r, lft_nxt;
  logic signed [PS_W-1:0]   p_r, p_nxt;
  logic                     stop_n_r, stop_n_nxt;
  logic                     fwd_n_r, fwd_n_nxt;
  logic [LEN_W-1:0]         len_r, len_nxt;
  logic [DIV_N-1:0]         dvd_r, dvd_nxt;
  logic [REM_W-1:0]         rem_r, rem_nxt;
  lsvr_pkg::out_word_t      out_data_r, out_data_nxt;

  logic              in_fire;
  logic              cfg_wr;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [ADDR_W-1:0] ram_raddr;
  logic [15:0]       ram_rdata;
  logic signed [15:0] rd_word;

  logic [IDX_W-1:0]     a_idx;
  logic [IDX_W:0]       b_idx;
  logic [IDX_W-1:0]     a_dec;
  logic [FRAC_BITS-1:0] frac;
  logic                 b_ge_len;
  logic                 b_ge_end;
  logic                 prev_ok;
  logic [ADDR_W-1:0]    a_addr;
  logic [ADDR_W-1:0]    rd2_addr;

  logic signed [PS_W-1:0] pos_s;
  logic signed [PS_W-1:0] adv_s;
  logic signed [PS_W-1:0] e_fx;
  logic signed [PS_W-1:0] s_fx;
  logic signed [PS_W-1:0] l_fx;
  logic signed [PS_W-1:0] lm1_fx;
  logic signed [PS_W-1:0] chk;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] mul_p;

  logic [REM_W-1:0] rem_sh;

  assign in_fire  = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loop_mode_r     <= '0;
      sample_length_r <= '0;
      loop_start_r    <= '0;
      loop_end_r      <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        lsvr_pkg::REG_LOOP_MODE:     loop_mode_r     <= pwdata[1:0];
        lsvr_pkg::REG_SAMPLE_LENGTH: sample_length_r <= pwdata[16:0];
        lsvr_pkg::REG_LOOP_START:    loop_start_r    <= pwdata[15:0];
        lsvr_pkg::REG_LOOP_END:      loop_end_r      <= pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lsvr_pkg::REG_LOOP_MODE:     prdata = 32'(loop_mode_r);
      lsvr_pkg::REG_SAMPLE_LENGTH: prdata = 32'(sample_length_r);
      lsvr_pkg::REG_LOOP_START:    prdata = 32'(loop_start_r);
      lsvr_pkg::REG_LOOP_END:      prdata = 32'(loop_end_r);
      default:                     prdata = '0;
    endcase
  end

  assign ram_we    = in_fire && (in_data.cmd == lsvr_pkg::CMD_LOAD);
  assign ram_waddr = ADDR_W'(in_data.addr);

  lsvr_ram #(
    .WIDTH(16),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_data.sample_in),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_word = signed'(ram_rdata);

  assign a_idx    = pos_r[POS_W-1:FRAC_BITS];
  assign b_idx    = (IDX_W+1)'(a_idx) + (IDX_W+1)'(1);
  assign a_dec    = a_idx - IDX_W'(1);
  assign frac     = pos_r[FRAC_BITS-1:0];
  assign b_ge_len = b_idx >= (IDX_W+1)'(sample_length_r);
  assign b_ge_end = b_idx >= (IDX_W+1)'(loop_end_r);
  assign prev_ok  = (a_idx != '0) && (a_dec > IDX_W'(loop_start_r));
  assign a_addr   = ADDR_W'(a_idx);

  always_comb begin
    if (loop_mode_r == lsvr_pkg::MODE_FORWARD && b_ge_end) begin
      rd2_addr = ADDR_W'(loop_start_r);
    end else if (loop_mode_r == lsvr_pkg::MODE_PINGPONG && !fwd_r) begin
      rd2_addr = ADDR_W'(a_dec);
    end else begin
      rd2_addr = ADDR_W'(b_idx);
    end
  end

  assign pos_s  = signed'(PS_W'(pos_r));
  assign adv_s  = signed'(PS_W'(adv_r));
  assign e_fx   = signed'(PS_W'(loop_end_r) << FRAC_BITS);
  assign s_fx   = signed'(PS_W'(loop_start_r) << FRAC_BITS);
  assign l_fx   = signed'(PS_W'(sample_length_r) << FRAC_BITS);
  assign lm1_fx = signed'((PS_W'(sample_length_r) - PS_W'(1)) << FRAC_BITS);
  assign chk    = (p_r >= l_fx) ? lm1_fx : p_r;

  assign mul_p  = mul_a * mul_b;
  assign rem_sh = {rem_r[REM_W-2:0], dvd_r[DIV_N-1]};

  always_comb begin
    state_nxt     = state_r;
    pos_nxt       = pos_r;
    fwd_nxt       = fwd_r;
    stopped_nxt   = stopped_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    silent_nxt    = silent_r;
    adv_nxt       = adv_r;
    vl_nxt        = vl_r;
    vr_nxt        = vr_r;
    cur_nxt       = cur_r;
    u_nxt         = u_r;
    v_nxt         = v_r;
    prod_nxt      = prod_r;
    s_nxt         = s_r;
    lft_nxt       = lft_r;
    p_nxt         = p_r;
    stop_n_nxt    = stop_n_r;
    fwd_n_nxt     = fwd_n_r;
    len_nxt       = len_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    out_data_nxt  = out_data_r;
    ram_raddr     = a_addr;
    mul_a         = s_r;
    mul_b         = signed'(MB_W'(vl_r));

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          unique case (in_data.cmd)
            lsvr_pkg::CMD_TRIGGER: begin
              pos_nxt     = '0;
              fwd_nxt     = 1'b1;
              stopped_nxt = 1'b0;
            end
            lsvr_pkg::CMD_STEP: begin
              adv_nxt    = in_data.advance;
              vl_nxt     = in_data.vol_left;
              vr_nxt     = in_data.vol_right;
              silent_nxt = stopped_r;
              state_nxt  = stopped_r ? S_DONE : S_RD1;
            end
            default: ;
          endcase
        end
      end
      S_RD1: state_nxt = S_RD2;
      S_RD2: begin
        cur_nxt   = rd_word;
        ram_raddr = rd2_addr;
        state_nxt = S_SEL;
      end
      S_SEL: begin
        u_nxt = cur_r;
        v_nxt = rd_word;
        case (loop_mode_r)
          lsvr_pkg::MODE_NONE: begin
            if (b_ge_len) begin
              v_nxt = '0;
            end
          end
          lsvr_pkg::MODE_PINGPONG: begin
            if (fwd_r) begin
              if (b_ge_end) begin
                v_nxt = cur_r;
              end
            end else begin
              v_nxt = cur_r;
              u_nxt = prev_ok ? rd_word : cur_r;
            end
          end
          lsvr_pkg::MODE_HOLD: v_nxt = '0;
          default: ;
        endcase
        state_nxt = S_MI;
      end
      S_MI: begin
        mul_a     = MA_W'(v_r) - MA_W'(u_r);
        mul_b     = signed'(MB_W'(frac));
        prod_nxt  = mul_p;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        s_nxt     = MA_W'(u_r) + MA_W'(prod_r >>> FRAC_BITS);
        state_nxt = S_ML;
      end
      S_ML: begin
        mul_b     = signed'(MB_W'(vl_r));
        prod_nxt  = mul_p;
        state_nxt = S_MR;
      end
      S_MR: begin
        lft_nxt   = lsvr_pkg::sat_q15(VP_W'(prod_r));
        mul_b     = signed'(MB_W'(vr_r));
        prod_nxt  = mul_p;
        state_nxt = S_PADV;
      end
      S_PADV: begin
        stop_n_nxt = 1'b0;
        fwd_n_nxt  = fwd_r;
        case (loop_mode_r)
          lsvr_pkg::MODE_HOLD:     p_nxt = pos_s;
          lsvr_pkg::MODE_PINGPONG: p_nxt = fwd_r ? pos_s + adv_s : pos_s - adv_s;
          default:                 p_nxt = pos_s + adv_s;
        endcase
        state_nxt = S_PFIX;
      end
      S_PFIX: begin
        state_nxt = S_PCHK;
        case (loop_mode_r)
          lsvr_pkg::MODE_NONE: begin
            if (p_r >= l_fx) begin
              stop_n_nxt = 1'b1;
            end
          end
          lsvr_pkg::MODE_FORWARD: begin
            if (p_r >= e_fx) begin
              if (e_fx > s_fx) begin
                len_nxt   = LEN_W'(e_fx - s_fx);
                dvd_nxt   = DIV_N'(p_r - s_fx);
                rem_nxt   = '0;
                cnt_nxt   = CNT_W'(DIV_N);
                state_nxt = S_DIV;
              end else begin
                p_nxt = s_fx;
              end
            end
          end
          lsvr_pkg::MODE_PINGPONG: begin
            if (fwd_r) begin
              if (p_r >= e_fx) begin
                fwd_n_nxt = 1'b0;
                p_nxt     = (e_fx <<< 1) - p_r;
              end
            end else if (p_r <= s_fx) begin
              fwd_n_nxt = 1'b1;
              p_nxt     = (s_fx <<< 1) - p_r;
            end
          end
          default: ;
        endcase
      end
      S_DIV: begin
        rem_nxt = (rem_sh >= REM_W'(len_r)) ? rem_sh - REM_W'(len_r) : rem_sh;
        dvd_nxt = dvd_r << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = S_WRAP;
        end
      end
      S_WRAP: begin
        p_nxt     = s_fx + signed'(PS_W'(rem_r));
        state_nxt = S_PCHK;
      end
      S_PCHK: begin
        if (loop_mode_r == lsvr_pkg::MODE_PINGPONG) begin
          if (fwd_r) begin
            if (p_r >= l_fx) begin
              fwd_n_nxt = 1'b0;
            end
            p_nxt = chk;
            if (chk[PS_W-1]) begin
              stop_n_nxt = 1'b1;
            end
          end else if (p_r[PS_W-1]) begin
            fwd_n_nxt = 1'b1;
            p_nxt     = '0;
          end
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.left_out  = silent_r ? '0 : lft_r;
          out_data_nxt.right_out = silent_r ? '0 : lsvr_pkg::sat_q15(VP_W'(prod_r));
          out_data_nxt.playing   = !silent_r;
          if (!silent_r) begin
            stopped_nxt = stop_n_r;
            fwd_nxt     = fwd_n_r;
            if (!stop_n_r) begin
              pos_nxt = POS_W'(p_r);
            end
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      fwd_r       <= 1'b1;
      stopped_r   <= 1'b1;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      silent_r    <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      fwd_r       <= fwd_nxt;
      stopped_r   <= stopped_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      silent_r    <= silent_nxt;
    end
  end

  always_ff @(posedge clk) begin
    adv_r      <= adv_nxt;
    vl_r       <= vl_nxt;
    vr_r       <= vr_nxt;
    cur_r      <= cur_nxt;
    u_r        <= u_nxt;
    v_r        <= v_nxt;
    prod_r     <= prod_nxt;
    s_r        <= s_nxt;
    lft_r      <= lft_nxt;
    p_r        <= p_nxt;
    stop_n_r   <= stop_n_nxt;
    fwd_n_r    <= fwd_n_nxt;
    len_r      <= len_nxt;
    dvd_r      <= dvd_nxt;
    rem_r      <= rem_nxt;
    out_data_r <= out_data_nxt;
  end

  `LSVR_ASSERT_NOW(a_rem_bound, state_r == S_DIV, rem_r < REM_W'(len_r), "remainder out of range")
  `LSVR_ASSERT_NEXT(a_trigger, in_fire && in_data.cmd == lsvr_pkg::CMD_TRIGGER, pos_r == '0 && fwd_r && !stopped_r, "trigger did not restart voice")
  `LSVR_ASSERT_NOW(a_silent, out_valid && !out_data.playing, out_data.left_out == '0 && out_data.right_out == '0, "stopped voice word not silent")
  `LSVR_ASSERT_NEXT(a_hold_pos, stopped_r && !(in_fire && in_data.cmd == lsvr_pkg::CMD_TRIGGER), $stable(pos_r), "position moved while stopped")

endmodule

>>> src/lsvr_ram.sv
`timescale 1ns / 1ps

module lsvr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] CMD_NOP = 2'd3;
  localparam int     FRAC_W     = 16;
  localparam longint POS_ONE    = 64'sd1 << FRAC_W;
  localparam int     TAIL       = 64;
  localparam int     LONG_HOLD  = 300;
  localparam int     WATCHDOG   = 4000;

  typedef struct {
    longint     pos;
    bit         fwd;
    bit         stopped;
    logic [1:0] mode;
    longint     len;
    longint     lstart;
    longint     lend;
  } voice_t;

  typedef struct packed {
    logic [15:0] u_addr;
    logic [15:0] v_addr;
    logic        v_zero;
  } taps_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  lsvr_pkg::in_word_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  lsvr_pkg::out_word_t out_data;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [3:0]          paddr = '0;
  logic [31:0]         pwdata = '0;
  logic [31:0]         prdata;
  logic                pready;

  voice_t              voice;
  voice_t              plan;
  logic signed [15:0]  pcm_mem [0:65535];
  bit                  loaded [0:65535];
  lsvr_pkg::in_word_t  pending_words[$];
  lsvr_pkg::out_word_t frames_due[$];

  int errors = 0;
  int frames_checked = 0;
  int send_gap = 0;
  int stall_left = 0;
  int quiet_cycles = 0;
  int pause;
  bit took;
  bit calm = 0;
  bit hold_request = 0;
  bit held_long = 0;

  looped_sample_voice_resampler dut (
    .clk, .rst_n,
    .in_valid, .in_ready, .in_data,
    .out_valid, .out_ready, .out_data,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial forever #1 clk = ~clk;

  function automatic taps_t voice_taps(voice_t st);
    taps_t  t;
    longint a, b, am1;
    a = st.pos >>> FRAC_W;
    b = a + 1;
    am1 = a - 1;
    t.u_addr = a[15:0];
    t.v_addr = b[15:0];
    t.v_zero = 1'b0;
    case (st.mode)
      lsvr_pkg::MODE_NONE: t.v_zero = (b >= st.len);
      lsvr_pkg::MODE_FORWARD: if (b >= st.lend) t.v_addr = st.lstart[15:0];
      lsvr_pkg::MODE_PINGPONG: begin
        if (st.fwd) begin
          if (b >= st.lend) t.v_addr = a[15:0];
        end else begin
          t.v_addr = a[15:0];
          if (a != 0 && am1 > st.lstart) t.u_addr = am1[15:0];
        end
      end
      default: t.v_zero = 1'b1;
    endcase
    return t;
  endfunction

  function automatic void voice_update(inout voice_t st, input lsvr_pkg::in_word_t w);
    longint p, e, s, l, span;
    if (w.cmd == lsvr_pkg::CMD_TRIGGER) begin
      st.pos = 0;
      st.fwd = 1'b1;
      st.stopped = 1'b0;
    end else if (w.cmd == lsvr_pkg::CMD_STEP && !st.stopped) begin
      p = st.pos;
      e = st.lend << FRAC_W;
      s = st.lstart << FRAC_W;
      l = st.len << FRAC_W;
      case (st.mode)
        lsvr_pkg::MODE_NONE: begin
          p = p + w.advance;
          if (p >= l) st.stopped = 1'b1;
        end
        lsvr_pkg::MODE_FORWARD: begin
          p = p + w.advance;
          if (p >= e) begin
            if (e > s) begin
              span = e - s;
              p = p - ((p - e) / span + 1) * span;
            end else begin
              p = s;
            end
          end
        end
        lsvr_pkg::MODE_PINGPONG: begin
          if (st.fwd) begin
            p = p + w.advance;
            if (p >= e) begin
              st.fwd = 1'b0;
              p = 2 * e - p;
            end
            if (p >= l) begin
              st.fwd = 1'b0;
              p = l - POS_ONE;
            end
            if (p < 0) st.stopped = 1'b1;
          end else begin
            p = p - w.advance;
            if (p <= s) begin
              st.fwd = 1'b1;
              p = 2 * s - p;
            end
            if (p < 0) begin
              st.fwd = 1'b1;
              p = 0;
            end
          end
        end
        default: ;
      endcase
      if (!st.stopped) st.pos = p;
    end
  endfunction

  function automatic void apply_reg(inout voice_t st, input logic [1:0] idx,
                                    input logic [31:0] val);
    case (idx)
      lsvr_pkg::REG_LOOP_MODE:     st.mode = val[1:0];
      lsvr_pkg::REG_SAMPLE_LENGTH: st.len = longint'(val[16:0]);
      lsvr_pkg::REG_LOOP_START:    st.lstart = longint'(val[15:0]);
      lsvr_pkg::REG_LOOP_END:      st.lend = longint'(val[16:0]);
      default: ;
    endcase
  endfunction

  function automatic logic signed [15:0] apply_gain(logic [15:0] vol, longint s);
    longint g, p;
    g = longint'(vol);
    p = (g * s) >>> 15;
    if (p > 32767) p = 32767;
    if (p < -32768) p = -32768;
    return p[15:0];
  endfunction

  function automatic void play_word(lsvr_pkg::in_word_t w);
    taps_t               t;
    lsvr_pkg::out_word_t r;
    longint              u, v, frac, s;
    t = voice_taps(voice);
    r = '0;
    if (w.cmd == lsvr_pkg::CMD_LOAD) pcm_mem[w.addr] = w.sample_in;
    if (w.cmd == lsvr_pkg::CMD_STEP && !voice.stopped) begin
      u = pcm_mem[t.u_addr];
      v = t.v_zero ? 0 : pcm_mem[t.v_addr];
      frac = voice.pos & 'hFFFF;
      s = u + (((v - u) * frac) >>> FRAC_W);
      r.left_out = apply_gain(w.vol_left, s);
      r.right_out = apply_gain(w.vol_right, s);
      r.playing = 1'b1;
    end
    voice_update(voice, w);
    if (w.cmd == lsvr_pkg::CMD_STEP) frames_due.push_back(r);
  endfunction

  function automatic lsvr_pkg::in_word_t make_word(logic [1:0] cmd);
    lsvr_pkg::in_word_t w;
    w.cmd = cmd;
    w.addr = 16'($urandom);
    w.sample_in = 16'($urandom);
    w.advance = 23'($urandom);
    w.vol_left = 16'($urandom);
    w.vol_right = 16'($urandom);
    return w;
  endfunction

  function automatic lsvr_pkg::in_word_t load_word(logic [15:0] addr, logic [15:0] data);
    lsvr_pkg::in_word_t w;
    w = make_word(lsvr_pkg::CMD_LOAD);
    w.addr = addr;
    w.sample_in = data;
    return w;
  endfunction

  function automatic lsvr_pkg::in_word_t step_word(logic [22:0] adv, logic [15:0] vl,
                                                   logic [15:0] vr);
    lsvr_pkg::in_word_t w;
    w = make_word(lsvr_pkg::CMD_STEP);
    w.advance = adv;
    w.vol_left = vl;
    w.vol_right = vr;
    return w;
  endfunction

  function automatic void preload(logic [15:0] addr);
    if (!loaded[addr]) begin
      loaded[addr] = 1'b1;
      pending_words.push_back(load_word(addr, 16'($urandom)));
    end
  endfunction

  function automatic void queue_word(lsvr_pkg::in_word_t w);
    taps_t t;
    if (w.cmd == lsvr_pkg::CMD_STEP && !plan.stopped) begin
      t = voice_taps(plan);
      preload(t.u_addr);
      if (!t.v_zero) preload(t.v_addr);
    end
    if (w.cmd == lsvr_pkg::CMD_LOAD) loaded[w.addr] = 1'b1;
    voice_update(plan, w);
    pending_words.push_back(w);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 75) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [22:0] pick_advance();
    case ($urandom_range(0, 19))
      0: return 23'($urandom);
      1: return '0;
      2: return '1;
      default: return 23'($urandom_range(1, 'h28000));
    endcase
  endfunction

  function automatic logic [15:0] pick_gain();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'd32768;
      2: return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  task automatic report(string msg);
    $display("MISMATCH frame %0d: %s", frames_checked, msg);
    errors++;
  endtask

  task automatic check_frame(lsvr_pkg::out_word_t got);
    lsvr_pkg::out_word_t want;
    if (frames_due.size() == 0) begin
      report($sformatf("unexpected word L=%0d R=%0d playing=%0b",
                       got.left_out, got.right_out, got.playing));
    end else begin
      want = frames_due.pop_front();
      if (got.left_out !== want.left_out)
        report($sformatf("left_out got %0d want %0d", got.left_out, want.left_out));
      if (got.right_out !== want.right_out)
        report($sformatf("right_out got %0d want %0d", got.right_out, want.right_out));
      if (got.playing !== want.playing)
        report($sformatf("playing got %0b want %0b", got.playing, want.playing));
    end
    frames_checked++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      took = in_valid && in_ready;
      if (took) play_word(in_data);
      if (!in_valid || took) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_data <= pending_words.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) check_frame(out_data);
    if (hold_request && !held_long) begin
      held_long <= 1'b1;
      stall_left <= LONG_HOLD;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else begin
      pause = pick_gap();
      if (pause > 0) begin
        stall_left <= pause - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic drain_voice();
    while (pending_words.size() != 0 || in_valid || frames_due.size() != 0)
      @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic cfg_write(logic [1:0] idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    apply_reg(voice, idx, val);
    apply_reg(plan, idx, val);
  endtask

  task automatic setup_voice(logic [1:0] mode, longint len, longint lstart, longint lend);
    drain_voice();
    cfg_write(lsvr_pkg::REG_LOOP_MODE, 32'(mode));
    cfg_write(lsvr_pkg::REG_SAMPLE_LENGTH, len[31:0]);
    cfg_write(lsvr_pkg::REG_LOOP_START, lstart[31:0]);
    cfg_write(lsvr_pkg::REG_LOOP_END, lend[31:0]);
  endtask

  task automatic random_setup();
    logic [1:0] mode;
    longint     len, lstart, lend, hi;
    mode = 2'($urandom_range(0, 3));
    case ($urandom_range(0, 9))
      0: len = 0;
      1: len = 65536;
      default: len = longint'($urandom_range(2, 48));
    endcase
    case ($urandom_range(0, 9))
      0: lstart = 0;
      1: lstart = 65535;
      default: lstart = longint'($urandom_range(0, 32'((len > 0) ? len - 1 : 0)));
    endcase
    hi = (len > lstart) ? len : lstart + 1;
    case ($urandom_range(0, 9))
      0: lend = 0;
      1: lend = 65536;
      2: lend = longint'($urandom_range(0, 32'(lstart)));
      default: lend = longint'($urandom_range(32'(lstart + 1), 32'(hi)));
    endcase
    setup_voice(mode, len, lstart, lend);
  endtask

  task automatic random_phase(int n);
    lsvr_pkg::in_word_t w;
    int                 r;
    queue_word(make_word(lsvr_pkg::CMD_TRIGGER));
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 7) begin
        queue_word(make_word(lsvr_pkg::CMD_TRIGGER));
      end else if (r < 15) begin
        w = make_word(lsvr_pkg::CMD_LOAD);
        if ($urandom_range(0, 3) != 0) w.addr = 16'($urandom_range(0, 63));
        queue_word(w);
      end else if (r < 18) begin
        queue_word(make_word(CMD_NOP));
      end else begin
        queue_word(step_word(pick_advance(), pick_gain(), pick_gain()));
      end
    end
  endtask

  initial begin
    voice = '{pos: 0, fwd: 1'b1, stopped: 1'b1, mode: lsvr_pkg::MODE_NONE,
              len: 0, lstart: 0, lend: 0};
    plan = voice;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    queue_word(step_word(23'h1234, 16'd32768, 16'd32768));
    queue_word(make_word(CMD_NOP));
    queue_word(load_word(16'hFFFF, 16'h7FFF));
    queue_word(make_word(lsvr_pkg::CMD_TRIGGER));
    queue_word(step_word(23'h8000, 16'd32768, 16'd0));
    queue_word(step_word(23'h8000, 16'd0, 16'd32768));

    setup_voice(lsvr_pkg::MODE_NONE, 4, 0, 0);
    queue_word(load_word(16'd0, 16'h8000));
    queue_word(load_word(16'd1, 16'h7FFF));
    queue_word(load_word(16'd2, 16'h0000));
    queue_word(load_word(16'd3, 16'hFFFF));
    queue_word(make_word(lsvr_pkg::CMD_TRIGGER));
    queue_word(step_word(23'h0, 16'd65535, 16'd32768));
    queue_word(step_word(23'h10000, 16'd32768, 16'd32768));
    queue_word(step_word(23'h8000, 16'd65535, 16'd65535));
    queue_word(step_word(23'h10000, 16'd32768, 16'd40000));
    queue_word(step_word(23'h20000, 16'd32768, 16'd1));
    queue_word(step_word(23'h10000, 16'd32768, 16'd32768));

    setup_voice(lsvr_pkg::MODE_FORWARD, 8, 2, 6);
    queue_word(make_word(lsvr_pkg::CMD_TRIGGER));
    queue_word(step_word(23'h7FFFFF, 16'd32768, 16'd16384));
    queue_word(step_word(23'h48000, 16'd32768, 16'd16384));

    setup_voice(lsvr_pkg::MODE_FORWARD, 8, 5, 3);
    queue_word(make_word(lsvr_pkg::CMD_TRIGGER));
    queue_word(step_word(23'h40000, 16'd32768, 16'd32768));
    queue_word(step_word(23'h8000, 16'd32768, 16'd32768));

    setup_voice(lsvr_pkg::MODE_PINGPONG, 65536, 65535, 4);
    queue_word(make_word(lsvr_pkg::CMD_TRIGGER));
    queue_word(step_word(23'h50000, 16'd32768, 16'd32768));
    queue_word(step_word(23'h10000, 16'd32768, 16'd32768));
    queue_word(step_word(23'h10000, 16'd32768, 16'd32768));

    setup_voice(lsvr_pkg::MODE_PINGPONG, 6, 1, 65536);
    queue_word(make_word(lsvr_pkg::CMD_TRIGGER));
    queue_word(step_word(23'h70000, 16'd32768, 16'd32768));
    queue_word(step_word(23'h20000, 16'd32768, 16'd32768));
    queue_word(step_word(23'h30000, 16'd32768, 16'd32768));

    setup_voice(lsvr_pkg::MODE_PINGPONG, 10, 0, 2);
    queue_word(make_word(lsvr_pkg::CMD_TRIGGER));
    queue_word(step_word(23'h7FFFFF, 16'd32768, 16'd32768));
    queue_word(step_word(23'h10000, 16'd32768, 16'd32768));

    setup_voice(lsvr_pkg::MODE_HOLD, 16, 0, 65536);
    queue_word(make_word(lsvr_pkg::CMD_TRIGGER));
    queue_word(step_word(23'h12345, 16'd32768, 16'd32768));
    queue_word(step_word(23'h12345, 16'd32768, 16'd32768));

    for (int phase = 0; phase < 13; phase++) begin
      random_setup();
      calm = ($urandom_range(0, 3) == 0);
      random_phase(40);
      if (phase == 3) hold_request = 1'b1;
    end

    drain_voice();
    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
